FILE: rtl/core/lph_pkg.sv
// ----------------------------------------------------------------------------
// lph_pkg
// Shared types and constants of the linear probing hash table.
// ----------------------------------------------------------------------------
package lph_pkg;

  localparam int unsigned KEY_W          = 32;
  localparam int unsigned VAL_W          = 64;
  localparam int unsigned SIZE_W         = 5;
  localparam int unsigned SLOT_W         = 4;
  localparam int unsigned APB_AW         = 3;
  localparam int unsigned APB_DW         = 32;
  localparam int unsigned MAX_USED_SLOTS = 31;
  localparam int unsigned TABLE_DEPTH_DEF = 16;
  localparam int unsigned VALUE_BITS_DEF  = 64;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = 5'd16;

  typedef enum logic {
    REG_TABLE_SIZE = 1'b0,
    REG_UNUSED     = 1'b1
  } lph_reg_e;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_SEARCH = 1'b1
  } lph_op_e;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_UPDATED  = 3'd1,
    ST_FULL     = 3'd2,
    ST_FOUND    = 3'd3,
    ST_MISSING  = 3'd4
  } lph_status_e;

  typedef struct packed {
    lph_op_e            op;
    logic [KEY_W-1:0]   key;
    logic [VAL_W-1:0]   value;
    logic [SIZE_W-1:0]  home;
    logic [SIZE_W-1:0]  used;
  } lph_item_t;

endpackage

FILE: rtl/core/lph_if.sv
// ----------------------------------------------------------------------------
// lph_if
// Valid/ready channels for requests into and results out of the hash table.
// ----------------------------------------------------------------------------
interface lph_in_if;
  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic [lph_pkg::KEY_W-1:0]  key;
  logic [lph_pkg::VAL_W-1:0]  value;

  modport source (output valid, output opcode, output key, output value, input ready);
  modport sink (input valid, input opcode, input key, input value, output ready);
endinterface

interface lph_out_if;
  logic                       valid;
  logic                       ready;
  logic [2:0]                 status;
  logic [lph_pkg::SLOT_W-1:0] slot;
  logic [lph_pkg::VAL_W-1:0]  found_value;

  modport source (output valid, output status, output slot, output found_value, input ready);
  modport sink (input valid, input status, input slot, input found_value, output ready);
endinterface

FILE: rtl/core/lph_ram.sv
// ----------------------------------------------------------------------------
// lph_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module lph_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/lph_fifo.sv
// ----------------------------------------------------------------------------
// lph_fifo
// Short queue of classified requests between the hashing and probing stages.
// ----------------------------------------------------------------------------
module lph_fifo #(
  parameter int unsigned DEPTH = lph_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  lph_pkg::lph_item_t item_i,
  output logic               full_o,
  input  logic               pop_i,
  output lph_pkg::lph_item_t item_o,
  output logic               empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  lph_pkg::lph_item_t  buf_q [DEPTH];
  logic [PTR_W-1:0]    wptr_q, wptr_d;
  logic [PTR_W-1:0]    rptr_q, rptr_d;
  logic [CNT_W-1:0]    count_q, count_d;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign item_o  = buf_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wptr_q] <= item_i;
    end
  end

endmodule

FILE: rtl/core/lph_front.sv
// ----------------------------------------------------------------------------
// lph_front
// Accepts requests, clamps the table size and computes the home slot with a
// radix-4 restoring divider, then queues the classified request.
// ----------------------------------------------------------------------------
module lph_front #(
  parameter int unsigned TABLE_DEPTH = lph_pkg::TABLE_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [lph_pkg::SIZE_W-1:0] table_size_i,
  lph_in_if.sink                     in_i,
  output logic                       push_o,
  output lph_pkg::lph_item_t         item_o,
  input  logic                       full_i
);

  localparam int unsigned USED_DEPTH =
    (TABLE_DEPTH < lph_pkg::MAX_USED_SLOTS) ? TABLE_DEPTH : lph_pkg::MAX_USED_SLOTS;
  localparam int unsigned DIV_STEPS = lph_pkg::KEY_W / 2;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);
  localparam int unsigned SW        = lph_pkg::SIZE_W;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_e;

  front_state_e                 state_q, state_d;
  lph_pkg::lph_op_e             op_q, op_d;
  logic [lph_pkg::KEY_W-1:0]    key_q, key_d;
  logic [lph_pkg::KEY_W-1:0]    div_q, div_d;
  logic [lph_pkg::VAL_W-1:0]    val_q, val_d;
  logic [SW-1:0]                used_q, used_d;
  logic [SW-1:0]                rem_q, rem_d;
  logic [CNT_W-1:0]             cnt_q, cnt_d;
  logic [SW-1:0]                used_now;
  logic [SW:0]                  trial1, trial2;
  logic [SW-1:0]                rem1;
  logic                         accept;

  always_comb begin
    if (table_size_i == '0) begin
      used_now = SW'(1);
    end else if (table_size_i > SW'(USED_DEPTH)) begin
      used_now = SW'(USED_DEPTH);
    end else begin
      used_now = table_size_i;
    end
  end

  assign in_i.ready = (state_q == F_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    trial1 = {rem_q, div_q[lph_pkg::KEY_W-1]};
    if (trial1 >= {1'b0, used_q}) begin
      trial1 = trial1 - {1'b0, used_q};
    end
    rem1   = trial1[SW-1:0];
    trial2 = {rem1, div_q[lph_pkg::KEY_W-2]};
    if (trial2 >= {1'b0, used_q}) begin
      trial2 = trial2 - {1'b0, used_q};
    end
  end

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    key_d   = key_q;
    div_d   = div_q;
    val_d   = val_q;
    used_d  = used_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    push_o  = 1'b0;
    unique case (state_q)
      F_IDLE: begin
        if (accept) begin
          op_d    = lph_pkg::lph_op_e'(in_i.opcode);
          key_d   = in_i.key;
          div_d   = in_i.key;
          val_d   = in_i.value;
          used_d  = used_now;
          rem_d   = '0;
          cnt_d   = '0;
          state_d = F_DIV;
        end
      end
      F_DIV: begin
        rem_d = trial2[SW-1:0];
        div_d = {div_q[lph_pkg::KEY_W-3:0], 2'b00};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    item_o.op    = op_q;
    item_o.key   = key_q;
    item_o.value = val_q;
    item_o.home  = rem_q;
    item_o.used  = used_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    key_q  <= key_d;
    div_q  <= div_d;
    val_q  <= val_d;
    used_q <= used_d;
    rem_q  <= rem_d;
  end

endmodule

FILE: rtl/core/lph_back.sv
// ----------------------------------------------------------------------------
// lph_back
// Walks the table from the home slot one probe per cycle, writes inserts and
// updates, and holds the result until it is taken.
// ----------------------------------------------------------------------------
module lph_back #(
  parameter int unsigned TABLE_DEPTH = lph_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned VALUE_BITS  = lph_pkg::VALUE_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  lph_pkg::lph_item_t item_i,
  output logic               pop_o,
  lph_out_if.source          out_o
);

  localparam int unsigned USED_DEPTH =
    (TABLE_DEPTH < lph_pkg::MAX_USED_SLOTS) ? TABLE_DEPTH : lph_pkg::MAX_USED_SLOTS;
  localparam int unsigned IDX_W = $clog2(USED_DEPTH);
  localparam int unsigned SW    = lph_pkg::SIZE_W;
  localparam int unsigned KW    = lph_pkg::KEY_W;
  localparam int unsigned ENT_W = KW + VALUE_BITS;

  typedef enum logic {
    B_IDLE,
    B_PROBE
  } back_state_e;

  back_state_e                 state_q, state_d;
  lph_pkg::lph_op_e            op_q, op_d;
  logic [KW-1:0]               key_q, key_d;
  logic [VALUE_BITS-1:0]       val_q, val_d;
  logic [SW-1:0]               used_q, used_d;
  logic [IDX_W-1:0]            idx_q, idx_d;
  logic [SW-1:0]               cnt_q, cnt_d;
  logic [USED_DEPTH-1:0]       valid_q, valid_d;
  logic                        res_valid_q, res_valid_d;
  lph_pkg::lph_status_e        status_q, status_d;
  logic [lph_pkg::SLOT_W-1:0]  slot_q, slot_d;
  logic [lph_pkg::VAL_W-1:0]   found_q, found_d;
  logic [IDX_W-1:0]            next_idx;
  logic                        ram_we, ram_re;
  logic [IDX_W-1:0]            ram_raddr;
  logic [ENT_W-1:0]            ram_rdata;
  logic                        slot_used, key_hit, last_probe;
  logic [lph_pkg::SLOT_W-1:0]  idx_slot;

  lph_ram #(
    .WIDTH (ENT_W),
    .DEPTH (USED_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i ({key_q, val_q}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign next_idx   = ((SW'(idx_q) + 1'b1) == used_q) ? '0 : idx_q + 1'b1;
  assign slot_used  = valid_q[idx_q];
  assign key_hit    = slot_used && (ram_rdata[ENT_W-1:VALUE_BITS] == key_q);
  assign last_probe = ((cnt_q + 1'b1) == used_q);
  assign idx_slot   = lph_pkg::SLOT_W'(SW'(idx_q));

  assign out_o.valid       = res_valid_q;
  assign out_o.status      = status_q;
  assign out_o.slot        = slot_q;
  assign out_o.found_value = found_q;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    key_d       = key_q;
    val_d       = val_q;
    used_d      = used_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    valid_d     = valid_q;
    res_valid_d = res_valid_q;
    status_d    = status_q;
    slot_d      = slot_q;
    found_d     = found_q;
    pop_o       = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = next_idx;
    if (out_o.valid && out_o.ready) begin
      res_valid_d = 1'b0;
    end
    unique case (state_q)
      B_IDLE: begin
        if (!empty_i && !res_valid_q) begin
          pop_o     = 1'b1;
          ram_re    = 1'b1;
          ram_raddr = IDX_W'(item_i.home);
          op_d      = item_i.op;
          key_d     = item_i.key;
          val_d     = item_i.value[VALUE_BITS-1:0];
          used_d    = item_i.used;
          idx_d     = IDX_W'(item_i.home);
          cnt_d     = '0;
          state_d   = B_PROBE;
        end
      end
      B_PROBE: begin
        if (!slot_used || key_hit || last_probe) begin
          state_d     = B_IDLE;
          res_valid_d = 1'b1;
          slot_d      = '0;
          found_d     = '0;
          status_d    = (op_q == lph_pkg::OP_INSERT) ? lph_pkg::ST_FULL : lph_pkg::ST_MISSING;
          if (!slot_used) begin
            if (op_q == lph_pkg::OP_INSERT) begin
              ram_we         = 1'b1;
              valid_d[idx_q] = 1'b1;
              status_d       = lph_pkg::ST_INSERTED;
              slot_d         = idx_slot;
            end
          end else if (key_hit) begin
            slot_d = idx_slot;
            if (op_q == lph_pkg::OP_INSERT) begin
              ram_we   = 1'b1;
              status_d = lph_pkg::ST_UPDATED;
            end else begin
              status_d = lph_pkg::ST_FOUND;
              found_d  = lph_pkg::VAL_W'(ram_rdata[VALUE_BITS-1:0]);
            end
          end
        end else begin
          ram_re = 1'b1;
          idx_d  = next_idx;
          cnt_d  = cnt_q + 1'b1;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      valid_q     <= '0;
      res_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      res_valid_q <= res_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    key_q    <= key_d;
    val_q    <= val_d;
    used_q   <= used_d;
    idx_q    <= idx_d;
    status_q <= status_d;
    slot_q   <= slot_d;
    found_q  <= found_d;
  end

endmodule

FILE: rtl/core/linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Key/value table with a division-method hash and wrapping linear probing.
// The front stage accepts a request, runs a radix-4 restoring divider that forms
// the home slot as key modulo the clamped table size, then hands the request off
// to the queue, and takes no new request before that hand-off. The back stage
// starts the walk, makes one probe of the table memory per cycle, and offers the
// finished result; it takes no new request from the queue while a result is
// offered and not yet taken. The two stages overlap through a
// two-entry queue, and the table is empty after reset with no clearing pass.
// ----------------------------------------------------------------------------
module linear_probe_hash_table #(
  parameter int unsigned TABLE_DEPTH = lph_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned VALUE_BITS  = lph_pkg::VALUE_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  lph_in_if.sink                     in_i,
  lph_out_if.source                  out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lph_pkg::APB_AW-1:0] paddr,
  input  logic [lph_pkg::APB_DW-1:0] pwdata,
  output logic [lph_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);

  logic [lph_pkg::SIZE_W-1:0] table_size_q, table_size_d;
  lph_pkg::lph_reg_e          reg_sel;
  logic                       cfg_write;
  logic                       q_push, q_pop, q_full, q_empty;
  lph_pkg::lph_item_t         q_in, q_out;

  assign reg_sel   = lph_pkg::lph_reg_e'(paddr[2]);
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    table_size_d = table_size_q;
    if (cfg_write && (reg_sel == lph_pkg::REG_TABLE_SIZE)) begin
      table_size_d = pwdata[lph_pkg::SIZE_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_sel)
      lph_pkg::REG_TABLE_SIZE: prdata = lph_pkg::APB_DW'(table_size_q);
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= lph_pkg::TABLE_SIZE_RST;
    end else begin
      table_size_q <= table_size_d;
    end
  end

  lph_front #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .table_size_i (table_size_q),
    .in_i         (in_i),
    .push_o       (q_push),
    .item_o       (q_in),
    .full_i       (q_full)
  );

  lph_fifo #(
    .DEPTH (lph_pkg::QUEUE_DEPTH_DEF)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .item_o  (q_out),
    .empty_o (q_empty)
  );

  lph_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_BITS  (VALUE_BITS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (q_empty),
    .item_i  (q_out),
    .pop_o   (q_pop),
    .out_o   (out_o)
  );

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && q_full))
    else $error("request pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_pop && q_empty))
    else $error("request popped from an empty queue");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("front stage ready while hashing a request");

  a_no_slot_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && ((out_o.status == lph_pkg::ST_FULL) ||
                     (out_o.status == lph_pkg::ST_MISSING)))
      |-> ((out_o.slot == '0) && (out_o.found_value == '0)))
    else $error("slot or value reported for a failed operation");

  a_value_only_on_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.status != lph_pkg::ST_FOUND)) |-> (out_o.found_value == '0))
    else $error("value reported for an operation other than a hit");

endmodule

FILE: test/linear_probe_hash_table_test.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table_test
// Drives insert and search transactions into the hash table under a fixed list of
// table sizes and random stalls on both channels. Each accepted request is
// run through a local model of the probed table, and every result transaction
// is checked field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH        = lph_pkg::TABLE_DEPTH_DEF;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned PHASE_OPS    = 50;

  typedef struct {
    lph_pkg::lph_op_e            op;
    logic [lph_pkg::KEY_W-1:0]   key;
    logic [lph_pkg::VAL_W-1:0]   value;
  } hash_op_t;

  typedef struct {
    lph_pkg::lph_status_e        status;
    logic [lph_pkg::SLOT_W-1:0]  slot;
    logic [lph_pkg::VAL_W-1:0]   found_value;
  } hash_reply_t;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  logic                       req_valid = 1'b0;
  lph_pkg::lph_op_e           req_op    = lph_pkg::OP_INSERT;
  logic [lph_pkg::KEY_W-1:0]  req_key   = '0;
  logic [lph_pkg::VAL_W-1:0]  req_value = '0;
  logic                       res_ready = 1'b0;

  logic                       psel    = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite  = 1'b0;
  logic [lph_pkg::APB_AW-1:0] paddr   = '0;
  logic [lph_pkg::APB_DW-1:0] pwdata  = '0;
  logic [lph_pkg::APB_DW-1:0] prdata;
  logic                       pready;

  lph_in_if  req_if ();
  lph_out_if res_if ();

  assign req_if.valid  = req_valid;
  assign req_if.opcode = req_op;
  assign req_if.key    = req_key;
  assign req_if.value  = req_value;
  assign res_if.ready  = res_ready;

  linear_probe_hash_table u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_n),
    .in_i    (req_if),
    .out_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk_i = ~clk_i;

  logic                       tbl_valid [DEPTH];
  logic [lph_pkg::KEY_W-1:0]  tbl_key   [DEPTH];
  logic [lph_pkg::VAL_W-1:0]  tbl_value [DEPTH];
  logic [lph_pkg::SIZE_W-1:0] cfg_size = lph_pkg::TABLE_SIZE_RST;

  hash_op_t    pending_ops[$];
  hash_reply_t expected_replies[$];

  logic        req_taken = 1'b0;
  logic        no_idle   = 1'b0;
  logic        hold_req  = 1'b0;
  int unsigned send_gap  = 0;
  int unsigned recv_gap  = 0;
  int unsigned hold_left = 0;
  int unsigned stall_cycles = 0;
  int unsigned errors = 0;

  function automatic hash_reply_t probe_table(lph_pkg::lph_op_e op,
                                              logic [lph_pkg::KEY_W-1:0] key,
                                              logic [lph_pkg::VAL_W-1:0] value);
    int unsigned used;
    int unsigned idx;
    hash_reply_t r;
    used = (cfg_size == 0) ? 1 : ((cfg_size > DEPTH) ? DEPTH : cfg_size);
    idx = key % used;
    r.status = (op == lph_pkg::OP_INSERT) ? lph_pkg::ST_FULL : lph_pkg::ST_MISSING;
    r.slot = '0;
    r.found_value = '0;
    for (int p = 0; p < used; p++) begin
      if (!tbl_valid[idx]) begin
        if (op == lph_pkg::OP_INSERT) begin
          tbl_valid[idx] = 1'b1;
          tbl_key[idx] = key;
          tbl_value[idx] = value;
          r.status = lph_pkg::ST_INSERTED;
          r.slot = lph_pkg::SLOT_W'(idx);
        end
        break;
      end
      if (tbl_key[idx] == key) begin
        if (op == lph_pkg::OP_INSERT) begin
          tbl_value[idx] = value;
          r.status = lph_pkg::ST_UPDATED;
        end else begin
          r.status = lph_pkg::ST_FOUND;
          r.found_value = tbl_value[idx];
        end
        r.slot = lph_pkg::SLOT_W'(idx);
        break;
      end
      idx = (idx + 1 == used) ? 0 : idx + 1;
    end
    return r;
  endfunction

  task automatic add_op(lph_pkg::lph_op_e op, logic [lph_pkg::KEY_W-1:0] key,
                        logic [lph_pkg::VAL_W-1:0] value);
    hash_op_t t;
    t.op = op;
    t.key = key;
    t.value = value;
    pending_ops.push_back(t);
  endtask

  task automatic write_table_size(logic [lph_pkg::SIZE_W-1:0] size);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= lph_pkg::APB_AW'(4 * int'(lph_pkg::REG_TABLE_SIZE));
    pwdata  <= {(lph_pkg::APB_DW - lph_pkg::SIZE_W)'($urandom), size};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_size = size;
  endtask

  task automatic drain();
    while (pending_ops.size() != 0 || req_valid || expected_replies.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  always @(negedge clk_i) begin : request_driver
    hash_op_t t;
    if (rst_n) begin
      if (!req_valid || req_taken) begin
        if (send_gap != 0) begin
          send_gap--;
          req_valid <= 1'b0;
        end else if (pending_ops.size() != 0 && !no_idle && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(0, 7);
          req_valid <= 1'b0;
        end else if (pending_ops.size() != 0) begin
          t = pending_ops.pop_front();
          req_valid <= 1'b1;
          req_op    <= t.op;
          req_key   <= t.key;
          req_value <= t.value;
        end else begin
          req_valid <= 1'b0;
        end
      end
      req_taken = 1'b0;
    end
  end

  always @(negedge clk_i) begin : reply_sink
    if (rst_n) begin
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_ready <= 1'b0;
      end else if (no_idle) begin
        res_ready <= 1'b1;
      end else if (recv_gap != 0) begin
        recv_gap--;
        res_ready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        recv_gap = $urandom_range(0, 7);
        res_ready <= 1'b0;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : reply_monitor
    hash_reply_t want;
    logic moved;
    if (rst_n) begin
      moved = 1'b0;
      if (res_if.valid && res_if.ready) begin
        moved = 1'b1;
        if (expected_replies.size() == 0) begin
          $error("result transaction with no request outstanding");
          errors++;
        end else begin
          want = expected_replies.pop_front();
          if (res_if.status !== want.status) begin
            $error("status expected %0d got %0d", want.status, res_if.status);
            errors++;
          end
          if (res_if.slot !== want.slot) begin
            $error("slot expected %0d got %0d", want.slot, res_if.slot);
            errors++;
          end
          if (res_if.found_value !== want.found_value) begin
            $error("found_value expected %h got %h", want.found_value, res_if.found_value);
            errors++;
          end
        end
      end
      if (req_valid && req_if.ready) begin
        moved = 1'b1;
        expected_replies.push_back(probe_table(req_op, req_key, req_value));
        req_taken = 1'b1;
      end
      if (moved)
        stall_cycles = 0;
      else if (pending_ops.size() != 0 || req_valid || expected_replies.size() != 0)
        stall_cycles++;
    end
  end

  initial begin : watchdog
    wait (stall_cycles >= STALL_LIMIT);
    $display("linear_probe_hash_table_test: errors");
    $finish;
  end

  initial begin : stimulus
    logic [lph_pkg::SIZE_W-1:0] sizes [10];
    logic [lph_pkg::KEY_W-1:0] k;
    sizes = '{5'd2, 5'd1, 5'd0, 5'd3, 5'd5, 5'd8, 5'd31, 5'd20, 5'd16, 5'd16};
    for (int i = 0; i < DEPTH; i++) tbl_valid[i] = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_n = 1'b1;

    // Reset size: home collisions, key extremes, update and a miss.
    add_op(lph_pkg::OP_INSERT, 32'h0000_0000, 64'h0);
    add_op(lph_pkg::OP_INSERT, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    add_op(lph_pkg::OP_SEARCH, 32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
    add_op(lph_pkg::OP_SEARCH, 32'hFFFF_FFFF, 64'h0);
    add_op(lph_pkg::OP_INSERT, 32'd16, 64'hA5A5_5A5A_0F0F_F0F0);
    add_op(lph_pkg::OP_SEARCH, 32'd16, 64'h0);
    add_op(lph_pkg::OP_SEARCH, 32'd32, 64'h0);
    add_op(lph_pkg::OP_INSERT, 32'h0000_0000, 64'h5555_AAAA_5555_AAAA);
    add_op(lph_pkg::OP_SEARCH, 32'h0000_0000, 64'h0);
    drain();

    // One slot left in use, holding the earlier contents of slot zero.
    write_table_size(5'd1);
    add_op(lph_pkg::OP_INSERT, 32'd7, 64'h1234_5678_9ABC_DEF0);
    add_op(lph_pkg::OP_SEARCH, 32'd9, 64'h0);
    add_op(lph_pkg::OP_SEARCH, 32'd0, 64'h0);
    add_op(lph_pkg::OP_INSERT, 32'd0, 64'hFEDC_BA98_7654_3210);
    drain();

    write_table_size(5'd0);
    add_op(lph_pkg::OP_INSERT, 32'd3, 64'h1);
    add_op(lph_pkg::OP_SEARCH, 32'd0, 64'h0);
    drain();

    write_table_size(5'd31);
    add_op(lph_pkg::OP_SEARCH, 32'd16, 64'h0);
    add_op(lph_pkg::OP_SEARCH, 32'hFFFF_FFFF, 64'h0);
    add_op(lph_pkg::OP_SEARCH, 32'd17, 64'h0);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      write_table_size(sizes[ph]);
      if (ph == 9) no_idle = 1'b1;
      for (int i = 0; i < PHASE_OPS; i++) begin
        case ($urandom_range(0, 9))
          7, 8:    k = 32'hFFFF_FFE0 | lph_pkg::KEY_W'($urandom_range(0, 31));
          9:       k = $urandom;
          default: k = lph_pkg::KEY_W'($urandom_range(0, 40));
        endcase
        add_op(lph_pkg::lph_op_e'($urandom_range(0, 1)), k, {$urandom, $urandom});
      end
      if (ph == 1) hold_req = 1'b1;
      drain();
    end

    if (errors == 0)
      $display("linear_probe_hash_table_test: clean");
    else
      $display("linear_probe_hash_table_test: errors");
    $finish;
  end

endmodule
